FILE: hw/rtl/bpc_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
package bpc_pkg;

  localparam int CAL_W    = 16;
  localparam int RAW_W    = 24;
  localparam int CFG_AW   = 3;
  localparam int TEMP_W   = 20;
  localparam int T1_W     = 19;
  localparam int WIDE_W   = 40;
  localparam int PRESS_W  = 32;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 56;

  localparam logic [CFG_AW-1:0] REG_PSENS = 3'd0;
  localparam logic [CFG_AW-1:0] REG_POFFS = 3'd1;
  localparam logic [CFG_AW-1:0] REG_TCS   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_TCO   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_TREF  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_TSENS = 3'd5;

  localparam logic [CAL_W-1:0] RST_PSENS = 16'd40127;
  localparam logic [CAL_W-1:0] RST_POFFS = 16'd36924;
  localparam logic [CAL_W-1:0] RST_TCS   = 16'd23317;
  localparam logic [CAL_W-1:0] RST_TCO   = 16'd23282;
  localparam logic [CAL_W-1:0] RST_TREF  = 16'd33464;
  localparam logic [CAL_W-1:0] RST_TSENS = 16'd28312;

  localparam logic signed [T1_W-1:0] T_REF_CENTI  = 19'sd2000;
  localparam logic signed [T1_W-1:0] T_COLD_CENTI = 19'sd1500;

  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sensitivity_temp_coef;
    logic [CAL_W-1:0] offset_temp_coef;
    logic [CAL_W-1:0] reference_temp;
    logic [CAL_W-1:0] temp_coef;
  } cal_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic signed [WIDE_W-1:0] offs;
    logic signed [WIDE_W-1:0] sens;
    logic [RAW_W-1:0]         raw_p;
  } comp_t;

endpackage

FILE: hw/rtl/bpc_cal_regs.sv
// Calibration word register file with write port.
module bpc_cal_regs
  import bpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CAL_W-1:0]  cfg_wdata,
  output cal_t              cal
);

  cal_t cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r.pressure_sensitivity  <= RST_PSENS;
      cal_r.pressure_offset       <= RST_POFFS;
      cal_r.sensitivity_temp_coef <= RST_TCS;
      cal_r.offset_temp_coef      <= RST_TCO;
      cal_r.reference_temp        <= RST_TREF;
      cal_r.temp_coef             <= RST_TSENS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PSENS: cal_r.pressure_sensitivity  <= cfg_wdata;
        REG_POFFS: cal_r.pressure_offset       <= cfg_wdata;
        REG_TCS:   cal_r.sensitivity_temp_coef <= cfg_wdata;
        REG_TCO:   cal_r.offset_temp_coef      <= cfg_wdata;
        REG_TREF:  cal_r.reference_temp        <= cfg_wdata;
        REG_TSENS: cal_r.temp_coef             <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cal = cal_r;

endmodule

FILE: hw/rtl/bpc_temp_pipe.sv
// Stages one to five: temperature, offset and sensitivity with corrections.
module bpc_temp_pipe
  import bpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cal_t             cal,
  input  logic             s_valid,
  output logic             s_ready,
  input  logic [RAW_W-1:0] s_raw_t,
  input  logic [RAW_W-1:0] s_raw_p,
  output logic             m_valid,
  input  logic             m_ready,
  output comp_t            m_data
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5    = !v5_r || m_ready;
  assign rdy4    = !v4_r || rdy5;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign s_ready = rdy1;
  assign m_valid = v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= s_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // stage 1: temperature difference
  logic signed [RAW_W:0] d1_r;
  logic [RAW_W-1:0]      rp1_r;
  logic signed [RAW_W:0] d_nxt;

  assign d_nxt = $signed({1'b0, s_raw_t}) - $signed({1'b0, cal.reference_temp, 8'd0});

  always_ff @(posedge clk) begin
    if (rdy1) begin
      d1_r  <= d_nxt;
      rp1_r <= s_raw_p;
    end
  end

  // stage 2: products of the difference
  logic signed [41:0] pt2_r, po2_r, ps2_r;
  logic signed [49:0] pdd2_r;
  logic [RAW_W-1:0]   rp2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      pt2_r  <= d1_r * $signed({1'b0, cal.temp_coef});
      po2_r  <= d1_r * $signed({1'b0, cal.offset_temp_coef});
      ps2_r  <= d1_r * $signed({1'b0, cal.sensitivity_temp_coef});
      pdd2_r <= d1_r * d1_r;
      rp2_r  <= rp1_r;
    end
  end

  // stage 3: first-order terms
  logic signed [T1_W-1:0]   t3_r;
  logic signed [WIDE_W-1:0] offs3_r, sens3_r;
  logic [16:0]              dd3_r;
  logic [RAW_W-1:0]         rp3_r;
  logic signed [T1_W-1:0]   t_nxt;
  logic signed [WIDE_W-1:0] offs_nxt, sens_nxt;

  assign t_nxt    = T_REF_CENTI + $signed(pt2_r[41:23]);
  assign offs_nxt = $signed({8'd0, cal.pressure_offset, 16'd0})
                  + $signed({{5{po2_r[41]}}, po2_r[41:7]});
  assign sens_nxt = $signed({9'd0, cal.pressure_sensitivity, 15'd0})
                  + $signed({{6{ps2_r[41]}}, ps2_r[41:8]});

  always_ff @(posedge clk) begin
    if (rdy3) begin
      t3_r    <= t_nxt;
      offs3_r <= offs_nxt;
      sens3_r <= sens_nxt;
      dd3_r   <= pdd2_r[47:31];
      rp3_r   <= rp2_r;
    end
  end

  // stage 4: squares for the cold corrections
  logic signed [T1_W-1:0]   t4_r;
  logic signed [WIDE_W-1:0] offs4_r, sens4_r;
  logic [16:0]              dd4_r;
  logic [RAW_W-1:0]         rp4_r;
  logic [34:0]              asq4_r, bsq4_r;
  logic                     low4_r, cold4_r;
  logic signed [T1_W-1:0]   am_nxt, bm_nxt;
  logic signed [2*T1_W-1:0] asq_nxt, bsq_nxt;

  assign am_nxt  = t3_r - T_REF_CENTI;
  assign bm_nxt  = t3_r + T_COLD_CENTI;
  assign asq_nxt = am_nxt * am_nxt;
  assign bsq_nxt = bm_nxt * bm_nxt;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      t4_r    <= t3_r;
      offs4_r <= offs3_r;
      sens4_r <= sens3_r;
      dd4_r   <= dd3_r;
      rp4_r   <= rp3_r;
      asq4_r  <= asq_nxt[34:0];
      bsq4_r  <= bsq_nxt[34:0];
      low4_r  <= t3_r < T_REF_CENTI;
      cold4_r <= t3_r < -T_COLD_CENTI;
    end
  end

  // stage 5: apply corrections
  logic [37:0]              a5_nxt, b7_nxt;
  logic [38:0]              b11_nxt;
  logic [WIDE_W-1:0]        offs_sub, sens_sub;
  logic signed [TEMP_W-1:0] t5_nxt;
  comp_t                    out5_r;

  assign a5_nxt  = {1'b0, asq4_r, 2'b00} + {3'd0, asq4_r};
  assign b7_nxt  = {bsq4_r, 3'b000} - {3'd0, bsq4_r};
  assign b11_nxt = {1'b0, bsq4_r, 3'b000} + {3'd0, bsq4_r, 1'b0} + {4'd0, bsq4_r};

  always_comb begin
    offs_sub = '0;
    sens_sub = '0;
    t5_nxt   = {t4_r[T1_W-1], t4_r};
    if (low4_r) begin
      offs_sub = {3'd0, a5_nxt[37:1]};
      sens_sub = {4'd0, a5_nxt[37:2]};
      t5_nxt   = {t4_r[T1_W-1], t4_r} - $signed({3'd0, dd4_r});
      if (cold4_r) begin
        offs_sub = offs_sub + {2'd0, b7_nxt};
        sens_sub = sens_sub + {2'd0, b11_nxt[38:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out5_r.temp  <= t5_nxt;
      out5_r.offs  <= offs4_r - $signed(offs_sub);
      out5_r.sens  <= sens4_r - $signed(sens_sub);
      out5_r.raw_p <= rp4_r;
    end
  end

  assign m_data = out5_r;

endmodule

FILE: hw/rtl/bpc_press_pipe.sv
// Stages six to eight: pressure product, scaling and output register.
module bpc_press_pipe
  import bpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s_valid,
  output logic                      s_ready,
  input  comp_t                     s_data,
  output logic                      m_valid,
  input  logic                      m_ready,
  output logic signed [PRESS_W-1:0] m_press,
  output logic signed [TEMP_W-1:0]  m_temp
);

  logic v6_r, v7_r, v8_r;
  logic rdy6, rdy7, rdy8;

  assign rdy8    = !v8_r || m_ready;
  assign rdy7    = !v7_r || rdy8;
  assign rdy6    = !v6_r || rdy7;
  assign s_ready = rdy6;
  assign m_valid = v8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      if (rdy6) v6_r <= s_valid;
      if (rdy7) v7_r <= v6_r;
      if (rdy8) v8_r <= v7_r;
    end
  end

  // stage 6: split product of raw pressure and sensitivity
  logic [43:0]              plo6_r;
  logic signed [44:0]       phi6_r;
  logic signed [WIDE_W-1:0] offs6_r;
  logic signed [TEMP_W-1:0] t6_r;

  always_ff @(posedge clk) begin
    if (rdy6) begin
      plo6_r  <= s_data.raw_p * s_data.sens[19:0];
      phi6_r  <= $signed({1'b0, s_data.raw_p}) * $signed(s_data.sens[39:20]);
      offs6_r <= s_data.offs;
      t6_r    <= s_data.temp;
    end
  end

  // stage 7: merge partial products
  logic [63:0]              x7_r;
  logic signed [WIDE_W-1:0] offs7_r;
  logic signed [TEMP_W-1:0] t7_r;

  always_ff @(posedge clk) begin
    if (rdy7) begin
      x7_r    <= {phi6_r[43:0], 20'd0} + {20'd0, plo6_r};
      offs7_r <= offs6_r;
      t7_r    <= t6_r;
    end
  end

  // stage 8: scale and subtract offset
  logic signed [43:0]        q_nxt;
  logic signed [PRESS_W-1:0] p8_r;
  logic signed [TEMP_W-1:0]  t8_r;

  assign q_nxt = $signed({x7_r[63], x7_r[63:21]}) - $signed({{4{offs7_r[WIDE_W-1]}}, offs7_r});

  always_ff @(posedge clk) begin
    if (rdy8) begin
      p8_r <= $signed({{3{q_nxt[43]}}, q_nxt[43:15]});
      t8_r <= t7_r;
    end
  end

  assign m_press = p8_r;
  assign m_temp  = t8_r;

endmodule

FILE: hw/rtl/baro_pressure_temp_compensation.sv
// Top level of the barometric pressure and temperature compensation block.
// An accepted item passes through every stage in order before out_tvalid rises.
// Throughput: one item per cycle unless stalled; each of the eight stages
// holds its item until the next frees; bubbles close up under backpressure.
// Reset (rst_n low, synchronous): all stages empty, calibration words loaded
// with their factory defaults.
module baro_pressure_temp_compensation
  import bpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CAL_W-1:0]  cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  // [23:0] raw_temperature, [47:24] raw_pressure
  input  logic [IN_W-1:0]   in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // [31:0] pressure_pa, [51:32] temperature_centi, [55:52] zero
  output logic [OUT_W-1:0]  out_tdata
);

  cal_t                      cal;
  comp_t                     comp;
  logic                      comp_valid, comp_ready;
  logic signed [PRESS_W-1:0] press;
  logic signed [TEMP_W-1:0]  temp;

  bpc_cal_regs u_cal (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cal       (cal)
  );

  bpc_temp_pipe u_temp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cal     (cal),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_raw_t (in_tdata[RAW_W-1:0]),
    .s_raw_p (in_tdata[2*RAW_W-1:RAW_W]),
    .m_valid (comp_valid),
    .m_ready (comp_ready),
    .m_data  (comp)
  );

  bpc_press_pipe u_press (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (comp_valid),
    .s_ready (comp_ready),
    .s_data  (comp),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_press (press),
    .m_temp  (temp)
  );

  assign out_tdata = {4'd0, temp, press};

endmodule

FILE: hw/rtl/bpc_checker.sv
// Port-level checker for the compensation block, with its bind.
module bpc_checker
  import bpc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output item changed or dropped");

  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input blocked while output drains");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_W-1:52] == 4'd0)
    else $error("output pad bits not zero");

endmodule

bind baro_pressure_temp_compensation bpc_checker u_bpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
